/* rtl/core/vdi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_pkg: shared types and constants
// Field widths and the command record passed from front to back end.
// ----------------------------------------------------------------------------
package vdi_pkg;
    localparam int unsigned DEFAULT_DEPTH = 1024;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned IDX_W = 10;
    localparam int unsigned CNT_W = 11;
    localparam int unsigned VTX_W = 8 * WORD_W;

    typedef struct packed {
        logic             first_of_mesh;
        logic [VTX_W-1:0] vtx;
    } vdi_cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             is_new;
        logic             table_full;
        logic [CNT_W-1:0] distinct_count;
    } vdi_res_t;
endpackage
`default_nettype wire

/* rtl/core/vdi_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_in_if / vdi_out_if: valid/ready channels
// Input vertex beats and result beats.
// ----------------------------------------------------------------------------
interface vdi_in_if;
    logic        valid;
    logic        ready;
    logic        first_of_mesh;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    modport source (output valid, first_of_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, input ready);
    modport sink (input valid, first_of_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
                  norm_x, norm_y, norm_z, output ready);
endinterface

interface vdi_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  vertex_index;
    logic        is_new;
    logic        table_full;
    logic [10:0] distinct_count;
    modport source (output valid, vertex_index, is_new, table_full, distinct_count,
                    input ready);
    modport sink (input valid, vertex_index, is_new, table_full, distinct_count,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/vdi_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_front: input stage and command queue
// Accepts vertex beats, packs them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module vdi_front (
    input  wire               clk,
    input  wire               rst_n,
    vdi_in_if.sink            in_ch,
    output vdi_pkg::vdi_cmd_t cmd,
    output logic              cmd_valid,
    input  wire               cmd_take
);
    import vdi_pkg::*;

    vdi_cmd_t   q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push;
    vdi_cmd_t   in_cmd;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (cnt_reg != 2'd0);
    assign cmd         = q_reg[rp_reg];

    // pack words low-first
    assign in_cmd.first_of_mesh = in_ch.first_of_mesh;
    assign in_cmd.vtx = {in_ch.norm_z, in_ch.norm_y, in_ch.norm_x, in_ch.tex_v,
                         in_ch.tex_u, in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, cmd_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (cmd_take)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= in_cmd;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid)
        else $error("take from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (cnt_reg == 2'd2 && !cmd_take) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
endmodule
`default_nettype wire

/* rtl/core/vdi_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_back: table search engine
// Scans stored entries in turn, appends new vertices if room, emits a result.
// ----------------------------------------------------------------------------
module vdi_back #(
    parameter int unsigned TABLE_DEPTH = vdi_pkg::DEFAULT_DEPTH
) (
    input  wire               clk,
    input  wire               rst_n,
    input  vdi_pkg::vdi_cmd_t cmd,
    input  wire               cmd_valid,
    output logic              cmd_take,
    vdi_out_if.source         out_ch
);
    import vdi_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [VTX_W-1:0] mem [TABLE_DEPTH];
    logic [VTX_W-1:0] rd_reg;
    logic [VTX_W-1:0] key_reg;
    logic [1:0]       st_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    ptr_reg;
    logic [AW-1:0]    cmp_idx_reg;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    vdi_res_t         res_reg, res_next;
    vdi_res_t         out_res_reg;
    logic             out_valid_reg;
    logic             out_fire;

    assign cmd_take = (st_reg == ST_IDLE) && cmd_valid;
    assign cnt_next = cmd.first_of_mesh ? '0 : cnt_reg;
    assign out_fire = (st_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.vertex_index   = out_res_reg.vertex_index;
    assign out_ch.is_new         = out_res_reg.is_new;
    assign out_ch.table_full     = out_res_reg.table_full;
    assign out_ch.distinct_count = out_res_reg.distinct_count;

    // decide outcome: hit, append of a new vertex, or table full
    always_comb
    begin
        res_next = '0;
        wr_en    = 1'b0;
        wr_addr  = cnt_reg[AW-1:0];
        if (st_reg == ST_CMP && rd_reg == key_reg)
        begin
            res_next.vertex_index   = IDX_W'(cmp_idx_reg);
            res_next.distinct_count = CNT_W'(cnt_reg);
        end
        else if (cnt_reg < CW'(TABLE_DEPTH))
        begin
            wr_en                   = 1'b1;
            res_next.vertex_index   = IDX_W'(cnt_reg);
            res_next.is_new         = 1'b1;
            res_next.distinct_count = CNT_W'(cnt_reg + 1'b1);
        end
        else
        begin
            res_next.table_full     = 1'b1;
            res_next.distinct_count = CNT_W'(cnt_reg);
        end
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    if (cmd_take)
                    begin
                        cnt_reg <= cnt_next;
                        ptr_reg <= '0;
                        st_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (ptr_reg < cnt_reg)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                        st_reg  <= ST_CMP;
                    end
                    else
                    begin
                        st_reg <= ST_OUT;
                    end
                end
                ST_CMP:
                begin
                    if (rd_reg == key_reg)
                        st_reg <= ST_OUT;
                    else
                        st_reg <= ST_SCAN;
                end
                ST_OUT:
                begin
                    if (out_fire)
                    begin
                        if (res_reg.is_new)
                            cnt_reg <= cnt_reg + 1'b1;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // key, result and table storage
    always_ff @(posedge clk)
    begin
        if (cmd_take)
            key_reg <= cmd.vtx;
        if (st_reg == ST_SCAN)
        begin
            rd_reg      <= mem[ptr_reg[AW-1:0]];
            cmp_idx_reg <= ptr_reg[AW-1:0];
        end
        if (st_reg == ST_CMP)
            res_reg <= res_next;
        if (st_reg == ST_SCAN && !(ptr_reg < cnt_reg))
            res_reg <= res_next;
        if (st_reg == ST_SCAN && !(ptr_reg < cnt_reg) && wr_en)
            mem[wr_addr] <= key_reg;
        // output beat holds steady while the next vertex is searched
        if (out_fire)
            out_res_reg <= res_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above depth");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (st_reg == ST_CMP) |-> (ptr_reg <= cnt_reg))
        else $error("read beyond written entries");
endmodule
`default_nettype wire

/* rtl/core/vertex_dedup_indexer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_dedup_indexer: exact-match vertex deduplication
// Returns first-appearance index of each vertex over a table of distinct ones.
// ----------------------------------------------------------------------------
// Per vertex the search engine takes a command in IDLE, then reads each stored
// entry in SCAN and compares it in CMP; a hit or the end of the entries leads
// to OUT. Throughput: one vertex at a time in the search engine, held by output
// stalls; a two-entry queue accepts further beats meanwhile. Reset clears
// counts and queue only; the table contents stay undefined and are never
// compared before written.
module vertex_dedup_indexer #(
    parameter int unsigned TABLE_DEPTH = vdi_pkg::DEFAULT_DEPTH
) (
    input  wire       clk,
    input  wire       rst_n,
    vdi_in_if.sink    in_ch,
    vdi_out_if.source out_ch
);
    import vdi_pkg::*;

    vdi_cmd_t cmd;
    logic     cmd_valid;
    logic     cmd_take;

    vdi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    vdi_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .out_ch    (out_ch)
    );
endmodule
`default_nettype wire
